// File: rtl/gshm_pkg.sv
// ----------------------------------------------------------------------------
// gshm_pkg
// Shared types and constants of the gas sensor heater cycle block.
// ----------------------------------------------------------------------------
package gshm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int TIME_W    = 24;
    localparam int AVG_W     = 16;
    localparam int FRAC_W    = 4;
    localparam int REC_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd2;

    localparam logic [TIME_W-1:0] HEAT_RESET    = 24'd60000;
    localparam logic [TIME_W-1:0] MEASURE_RESET = 24'd90000;
    localparam logic [TIME_W-1:0] SETTLE_RESET  = 24'd20000;
    localparam logic [TIME_W-1:0] ELAPSED_RESET = 24'hFFFFFF;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    // Head of the queue as the back end sees it.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } t_back_state;

endpackage

// File: rtl/gshm_front.sv
// ----------------------------------------------------------------------------
// gshm_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gshm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [gshm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_pop,
    output gshm_pkg::t_queue_head         o_head
);
    import gshm_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        push;
    logic        pop;
    t_item       in_item;

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != 2'd0);

    always_comb begin
        in_item.op     = i_kind ? OP_SAMPLE : OP_TICK;
        in_item.sample = i_sample;
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rptr];

endmodule

// File: rtl/gshm_divider.sv
// ----------------------------------------------------------------------------
// gshm_divider
// Restoring divider, one dividend bit per cycle, quotient truncated.
// ----------------------------------------------------------------------------
module gshm_divider #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 11,
    parameter int QUO_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quotient
);
    localparam int ITER_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    trial;
    logic              fits;
    logic [DVS_W:0]    diff;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(DVD_W);
            end else if (r_busy) begin
                r_iter <= r_iter - ITER_W'(1);
                if (r_iter == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient is known to fit QUO_W bits, so upper zero bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/gshm_back.sv
// ----------------------------------------------------------------------------
// gshm_back
// Phase sequencer, sample accumulator and record output register.
// ----------------------------------------------------------------------------
module gshm_back #(
    parameter int MAX_SAMPLES = 1024,
    parameter int CNT_W       = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gshm_pkg::t_queue_head          i_head,
    output logic                           o_pop,
    input  logic                           i_cfg_valid,
    input  logic [gshm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gshm_pkg::TIME_W-1:0]    i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_heater_on,
    output logic                           o_record_valid,
    output logic [gshm_pkg::AVG_W-1:0]     o_average,
    output logic [CNT_W-1:0]               o_sample_count,
    output logic                           o_no_samples,
    output logic [gshm_pkg::REC_W-1:0]     o_record_number
);
    import gshm_pkg::*;

    localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * MAX_SAMPLES + 1);
    localparam int DVD_W = SUM_W + FRAC_W;

    logic [TIME_W-1:0] r_heat;
    logic [TIME_W-1:0] r_measure;
    logic [TIME_W-1:0] r_settle;

    t_back_state       r_state, n_state;
    logic              r_measuring, n_measuring;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic              r_settled, n_settled;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [REC_W-1:0]  r_records, n_records;

    logic              r_out_valid, n_out_valid;
    logic              r_o_heater, n_o_heater;
    logic              r_o_rec, n_o_rec;
    logic [AVG_W-1:0]  r_o_avg, n_o_avg;
    logic [CNT_W-1:0]  r_o_cnt, n_o_cnt;
    logic              r_o_none, n_o_none;
    logic [REC_W-1:0]  r_o_num, n_o_num;

    logic              div_start;
    logic              div_done;
    logic [AVG_W-1:0]  div_quo;
    logic [TIME_W:0]   next_elapsed;
    logic [TIME_W-1:0] phase_len;

    assign next_elapsed = {1'b0, r_elapsed} + {{TIME_W{1'b0}}, 1'b1};
    assign phase_len    = r_measuring ? r_measure : r_heat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat    <= HEAT_RESET;
            r_measure <= MEASURE_RESET;
            r_settle  <= SETTLE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HEAT:    r_heat    <= i_cfg_data;
                REG_MEASURE: r_measure <= i_cfg_data;
                REG_SETTLE:  r_settle  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_measuring = r_measuring;
        n_elapsed   = r_elapsed;
        n_settled   = r_settled;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_records   = r_records;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_heater  = r_o_heater;
        n_o_rec     = r_o_rec;
        n_o_avg     = r_o_avg;
        n_o_cnt     = r_o_cnt;
        n_o_none    = r_o_none;
        n_o_num     = r_o_num;
        o_pop       = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid && !r_out_valid) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_o_rec     = 1'b0;
                    n_o_avg     = '0;
                    n_o_cnt     = '0;
                    n_o_none    = 1'b0;
                    n_o_num     = '0;
                    if (i_head.item.op == OP_TICK) begin
                        if (next_elapsed > {1'b0, phase_len}) begin
                            n_elapsed = '0;
                            if (r_measuring) begin
                                n_measuring = 1'b0;
                                n_settled   = 1'b0;
                                n_sum       = '0;
                                n_cnt       = '0;
                                n_records   = r_records + REC_W'(1);
                                n_o_rec     = 1'b1;
                                n_o_cnt     = r_cnt;
                                n_o_num     = r_records;
                                if (r_cnt == '0) begin
                                    n_o_none = 1'b1;
                                end else begin
                                    // Result waits for the quotient.
                                    div_start   = 1'b1;
                                    n_out_valid = 1'b0;
                                    n_state     = ST_DIV;
                                end
                            end else begin
                                n_measuring = 1'b1;
                                n_settled   = (r_settle == '0);
                            end
                        end else begin
                            n_elapsed = next_elapsed[TIME_W-1:0];
                            if (r_measuring && (next_elapsed >= {1'b0, r_settle})) begin
                                n_settled = 1'b1;
                            end
                        end
                    end else begin
                        if (r_measuring && r_settled && (r_cnt < CNT_W'(MAX_SAMPLES))) begin
                            n_cnt = r_cnt + CNT_W'(1);
                            n_sum = r_sum + SUM_W'(i_head.item.sample);
                        end
                    end
                    n_o_heater = !n_measuring;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_o_avg     = div_quo;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_measuring <= 1'b0;
            r_elapsed   <= ELAPSED_RESET;
            r_settled   <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_records   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_measuring <= n_measuring;
            r_elapsed   <= n_elapsed;
            r_settled   <= n_settled;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_records   <= n_records;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_heater <= n_o_heater;
        r_o_rec    <= n_o_rec;
        r_o_avg    <= n_o_avg;
        r_o_cnt    <= n_o_cnt;
        r_o_none   <= n_o_none;
        r_o_num    <= n_o_num;
    end

    gshm_divider #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W),
        .QUO_W (AVG_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum, {FRAC_W{1'b0}}}),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_out_valid     = r_out_valid;
    assign o_heater_on     = r_o_heater;
    assign o_record_valid  = r_o_rec;
    assign o_average       = r_o_avg;
    assign o_sample_count  = r_o_cnt;
    assign o_no_samples    = r_o_none;
    assign o_record_number = r_o_num;

endmodule

// File: rtl/gas_sensor_heat_measure_cycle.sv
// ----------------------------------------------------------------------------
// gas_sensor_heat_measure_cycle
// Gas sensor heater sequencer with averaged measurement records.
// ----------------------------------------------------------------------------
// Every input transaction (a tick or a converter sample) produces exactly one
// result transaction carrying the heater level after it; the tick that ends a
// measure phase also carries the record. Inputs enter a two-entry queue, so
// the source can keep sending while a result waits for the sink. An item
// passes the queue and then the sequencer, whose outputs are registered; the
// tick that closes a record with samples also waits for the bit-per-cycle
// divider that forms the 12.4 average. Configuration writes
// are always ready and must be issued while no item is in flight.
// ----------------------------------------------------------------------------
module gas_sensor_heat_measure_cycle #(
    parameter int MAX_SAMPLES = 1024,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [gshm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_heater_on,
    output logic                           o_record_valid,
    output logic [gshm_pkg::AVG_W-1:0]     o_average,
    output logic [CNT_W-1:0]               o_sample_count,
    output logic                           o_no_samples,
    output logic [gshm_pkg::REC_W-1:0]     o_record_number,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gshm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gshm_pkg::TIME_W-1:0]    i_cfg_data
);
    import gshm_pkg::*;

    t_queue_head head;
    logic        pop;

    assign o_cfg_ready = 1'b1;

    gshm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_sample   (i_sample),
        .i_pop      (pop),
        .o_head     (head)
    );

    gshm_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_heater_on     (o_heater_on),
        .o_record_valid  (o_record_valid),
        .o_average       (o_average),
        .o_sample_count  (o_sample_count),
        .o_no_samples    (o_no_samples),
        .o_record_number (o_record_number)
    );

endmodule

// File: sim/gas_sensor_heat_measure_cycle_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gas_sensor_heat_measure_cycle_test
// Self-checking testbench for the gas sensor heater sequencer.
// ----------------------------------------------------------------------------
// Ticks and converter samples are sent to the block. A cycle-free model of
// the sequencer predicts the heater level and every measurement record, and
// each result is checked against it in order. A short directed table covers
// reset behavior, field extremes, empty records, full-scale samples and live register
// changes. Random phases under varied settings and flow control follow,
// including a long receiver hold-off and a burst that saturates the count.
// ----------------------------------------------------------------------------
module gas_sensor_heat_measure_cycle_test;
    import gshm_pkg::*;

    localparam int MAX_SAMPLES  = 1024;
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W        = SAMPLE_W + CNT_W - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int SAT_BURST    = 1030;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 25;

    localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                heater_on;
        logic                record_valid;
        logic [AVG_W-1:0]    average;
        logic [CNT_W-1:0]    sample_count;
        logic                no_samples;
        logic [REC_W-1:0]    record_number;
    } t_cycle_result;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_REG  = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind            act;
        t_op                  op;
        logic [SAMPLE_W-1:0]  smp;
        logic [CFG_IDX_W-1:0] idx;
        logic [TIME_W-1:0]    data;
        bit                   has_exp;
        t_cycle_result        exp;
    } t_row;

    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_kind   = OP_TICK;
    logic [SAMPLE_W-1:0]  in_sample = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HEAT;
    logic [TIME_W-1:0]    cfg_data  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 heater_on;
    logic                 record_valid;
    logic [AVG_W-1:0]     average;
    logic [CNT_W-1:0]     sample_count;
    logic                 no_samples;
    logic [REC_W-1:0]     record_number;
    logic                 cfg_ready;

    // Sequencer model state and its copy of the registers.
    logic [TIME_W-1:0]    seq_heat;
    logic [TIME_W-1:0]    seq_measure;
    logic [TIME_W-1:0]    seq_settle;
    logic                 seq_measuring;
    logic [TIME_W-1:0]    seq_elapsed;
    logic                 seq_settled;
    logic [SUM_W-1:0]     seq_sum;
    logic [CNT_W-1:0]     seq_count;
    logic [REC_W-1:0]     seq_records;

    t_cycle_result        pending_results[$];
    t_row                 directed_rows[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int records_seen  = 0;
    int full_records  = 0;
    int empty_records = 0;
    int reg_writes    = 0;

    gas_sensor_heat_measure_cycle #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (in_kind),
        .i_sample       (in_sample),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_heater_on    (heater_on),
        .o_record_valid (record_valid),
        .o_average      (average),
        .o_sample_count (sample_count),
        .o_no_samples   (no_samples),
        .o_record_number(record_number),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advances the sequencer model by one item and returns its result.
    function automatic t_cycle_result advance_sequencer(t_op op, logic [SAMPLE_W-1:0] smp);
        logic [TIME_W:0]         next_elapsed;
        logic [TIME_W-1:0]       phase_len;
        logic [SUM_W+FRAC_W-1:0] scaled;
        t_cycle_result           r;
        r = '0;
        if (op == OP_TICK) begin
            // The increment is one bit wider, so the reset value always expires.
            next_elapsed = {1'b0, seq_elapsed} + (TIME_W+1)'(1);
            phase_len = seq_measuring ? seq_measure : seq_heat;
            if (next_elapsed > {1'b0, phase_len}) begin
                if (seq_measuring) begin
                    r.record_valid  = 1'b1;
                    r.sample_count  = seq_count;
                    r.record_number = seq_records;
                    if (seq_count == '0) begin
                        r.no_samples = 1'b1;
                    end else begin
                        scaled = {seq_sum, {FRAC_W{1'b0}}};
                        r.average = AVG_W'(scaled / seq_count);
                    end
                    seq_records   = seq_records + REC_W'(1);
                    seq_sum       = '0;
                    seq_count     = '0;
                    seq_settled   = 1'b0;
                    seq_measuring = 1'b0;
                end else begin
                    seq_measuring = 1'b1;
                    seq_settled   = (seq_settle == '0);
                end
                seq_elapsed = '0;
            end else begin
                seq_elapsed = next_elapsed[TIME_W-1:0];
                if (seq_measuring && next_elapsed >= {1'b0, seq_settle}) begin
                    seq_settled = 1'b1;
                end
            end
        end else if (seq_measuring && seq_settled && seq_count < CNT_W'(MAX_SAMPLES)) begin
            seq_count = seq_count + CNT_W'(1);
            seq_sum   = seq_sum + SUM_W'(smp);
        end
        r.heater_on = !seq_measuring;
        return r;
    endfunction

    function automatic t_row item_row(t_op op, logic [SAMPLE_W-1:0] smp);
        t_row row;
        row.act     = ROW_ITEM;
        row.op      = op;
        row.smp     = smp;
        row.idx     = REG_HEAT;
        row.data    = '0;
        row.has_exp = 1'b0;
        row.exp     = '0;
        return row;
    endfunction

    function automatic t_row typed_row(t_op op, logic [SAMPLE_W-1:0] smp, t_cycle_result r);
        t_row row;
        row = item_row(op, smp);
        row.has_exp = 1'b1;
        row.exp     = r;
        return row;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        t_row row;
        row = item_row(OP_TICK, '0);
        row.act  = ROW_REG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] smp;
        case ($urandom_range(0, 7))
            0: smp = '0;
            1: smp = '1;
            default: smp = SAMPLE_W'($urandom);
        endcase
        return smp;
    endfunction

    task automatic send_item(input t_op op, input logic [SAMPLE_W-1:0] smp,
                             input bit use_typed, input t_cycle_result typed);
        int            gap;
        t_cycle_result predicted;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_kind   <= op;
        in_sample <= smp;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predicted = advance_sequencer(op, smp);
        pending_results.push_back(use_typed ? typed : predicted);
        items_sent++;
    endtask

    // Lets every expected result arrive, then waits out the drain period.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            REG_HEAT:    seq_heat    = data;
            REG_MEASURE: seq_measure = data;
            REG_SETTLE:  seq_settle  = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Mostly short phases so that records come often; now and then one
    // register goes to an extreme.
    task automatic choose_setting();
        logic [TIME_W-1:0] heat_len;
        logic [TIME_W-1:0] meas_len;
        logic [TIME_W-1:0] settle_len;
        heat_len   = TIME_W'($urandom_range(1, 8));
        meas_len   = TIME_W'($urandom_range(1, 12));
        settle_len = TIME_W'($urandom_range(0, 32'(meas_len) + 2));
        case ($urandom_range(0, 9))
            0: heat_len   = TIME_MAX;
            1: meas_len   = TIME_MAX;
            2: settle_len = TIME_MAX;
            3: settle_len = '0;
            default: ;
        endcase
        wait_idle();
        write_reg(REG_HEAT, heat_len);
        write_reg(REG_MEASURE, meas_len);
        write_reg(REG_SETTLE, settle_len);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE, TIME_W'($urandom));
        end
    endtask

    task automatic send_random_items(input int count);
        t_op op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < 45) ? OP_TICK : OP_SAMPLE;
            send_item(op, pick_sample(), 1'b0, '0);
        end
    endtask

    // Receiver flow control: random stalls, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cycle_result got;
        t_cycle_result want;
        bit            bad;
        if (rst_n && out_valid && !out_stall) begin
            got.heater_on     = heater_on;
            got.record_valid  = record_valid;
            got.average       = average;
            got.sample_count  = sample_count;
            got.no_samples    = no_samples;
            got.record_number = record_number;
            results_seen++;
            if (got.record_valid === 1'b1) begin
                records_seen++;
                if (got.sample_count == MAX_SAMPLES) full_records++;
                if (got.no_samples === 1'b1) empty_records++;
            end
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result transaction %0d: heater %0b record %0b",
                             results_seen, got.heater_on, got.record_valid);
                end
            end else begin
                want = pending_results.pop_front();
                bad = (got.heater_on !== want.heater_on)
                    || (got.record_valid !== want.record_valid)
                    || (got.average !== want.average)
                    || (got.sample_count !== want.sample_count)
                    || (got.no_samples !== want.no_samples)
                    || (got.record_number !== want.record_number);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch on result %0d at %0t", results_seen, $realtime);
                        $display("  expected heater %0b rec %0b avg %0d cnt %0d empty %0b num %0d",
                                 want.heater_on, want.record_valid, want.average,
                                 want.sample_count, want.no_samples, want.record_number);
                        $display("  actual   heater %0b rec %0b avg %0d cnt %0d empty %0b num %0d",
                                 got.heater_on, got.record_valid, got.average,
                                 got.sample_count, got.no_samples, got.record_number);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        seq_heat      = HEAT_RESET;
        seq_measure   = MEASURE_RESET;
        seq_settle    = SETTLE_RESET;
        seq_measuring = 1'b0;
        seq_elapsed   = ELAPSED_RESET;
        seq_settled   = 1'b0;
        seq_sum       = '0;
        seq_count     = '0;
        seq_records   = '0;

        // Reset values: a sample in heat is ignored, the first tick enters
        // measure and samples wait for the long default settle time.
        directed_rows.push_back(typed_row(OP_SAMPLE, 12'hFFF,
                                t_cycle_result'{1'b1, 1'b0, 16'd0, 11'd0, 1'b0, 32'd0}));
        directed_rows.push_back(typed_row(OP_TICK, 12'h000,
                                t_cycle_result'{1'b0, 1'b0, 16'd0, 11'd0, 1'b0, 32'd0}));
        directed_rows.push_back(typed_row(OP_SAMPLE, 12'h000,
                                t_cycle_result'{1'b0, 1'b0, 16'd0, 11'd0, 1'b0, 32'd0}));
        directed_rows.push_back(reg_row(REG_HEAT, 24'd2));
        directed_rows.push_back(reg_row(REG_MEASURE, 24'd3));
        directed_rows.push_back(reg_row(REG_SETTLE, 24'd0));
        directed_rows.push_back(reg_row(REG_SPARE, 24'hA5A5A5));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'hFFF));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'h000));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'hFFF));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        // Two full-scale samples and a zero give two thirds of the largest average.
        directed_rows.push_back(typed_row(OP_TICK, 12'h000,
                                t_cycle_result'{1'b1, 1'b1, 16'd43680, 11'd3, 1'b0, 32'd0}));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'h07B));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        directed_rows.push_back(reg_row(REG_SETTLE, TIME_MAX));
        directed_rows.push_back(reg_row(REG_MEASURE, 24'd1));
        directed_rows.push_back(typed_row(OP_TICK, 12'h000,
                                t_cycle_result'{1'b0, 1'b0, 16'd0, 11'd0, 1'b0, 32'd0}));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'h007));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        // Settle time never reached, so the record is empty.
        directed_rows.push_back(typed_row(OP_TICK, 12'h000,
                                t_cycle_result'{1'b1, 1'b1, 16'd0, 11'd0, 1'b1, 32'd1}));
        directed_rows.push_back(reg_row(REG_HEAT, TIME_MAX));
        directed_rows.push_back(reg_row(REG_MEASURE, TIME_MAX));
        directed_rows.push_back(reg_row(REG_SETTLE, 24'd0));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        // Shortening a running phase ends it on the next tick.
        directed_rows.push_back(reg_row(REG_HEAT, 24'd1));
        directed_rows.push_back(typed_row(OP_TICK, 12'h000,
                                t_cycle_result'{1'b0, 1'b0, 16'd0, 11'd0, 1'b0, 32'd0}));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'h001));
        directed_rows.push_back(item_row(OP_SAMPLE, 12'h002));
        directed_rows.push_back(reg_row(REG_MEASURE, 24'd1));
        directed_rows.push_back(reg_row(REG_SETTLE, TIME_MAX));
        directed_rows.push_back(item_row(OP_TICK, 12'h000));
        directed_rows.push_back(typed_row(OP_TICK, 12'h000,
                                t_cycle_result'{1'b1, 1'b1, 16'd24, 11'd2, 1'b0, 32'd2}));

        send_idle_pct = 32;
        recv_idle_pct = 76;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].act == ROW_REG) begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_item(directed_rows[i].op, directed_rows[i].smp,
                          directed_rows[i].has_exp, directed_rows[i].exp);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 76 : 0;
            recv_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 32 : 0;
            if (mode == 2) begin
                // The receiver holds off while a long sample burst fills the
                // block, and the burst runs past the count limit.
                wait_idle();
                write_reg(REG_HEAT, 24'd1);
                write_reg(REG_MEASURE, 24'd2);
                write_reg(REG_SETTLE, 24'd0);
                hold_requests++;
                while (!seq_measuring) send_item(OP_TICK, '0, 1'b0, '0);
                for (int i = 0; i < SAT_BURST; i++) begin
                    send_item(OP_SAMPLE, pick_sample(), 1'b0, '0);
                end
                while (seq_measuring) send_item(OP_TICK, '0, 1'b0, '0);
            end
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                choose_setting();
                send_random_items(SEG_ITEMS);
            end
        end

        wait_idle();
        $display("Sent %0d transactions with %0d register writes across three flow-control modes.",
                 items_sent, reg_writes);
        $display("Saw %0d records: %0d empty, %0d at the sample limit; %0d mismatches.",
                 records_seen, empty_records, full_records, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
